### rtl/sysex_seven_bit_packer_macros.svh
// assertion macros for the sysex seven-bit packer
`ifndef SYSEX_SEVEN_BIT_PACKER_MACROS_SVH
`define SYSEX_SEVEN_BIT_PACKER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ssp_pkg.sv
// shared types and constants of the sysex seven-bit packer
package ssp_pkg;

  localparam int GROUP_SIZE     = 7;
  localparam int BYTE_W         = 8;
  localparam int SEPT_W         = 7;
  localparam int FILL_W         = 3;
  localparam int LIMIT_W        = 20;
  localparam int TOTAL_W        = 20;
  localparam int COUNT_BITS_DEF = 20;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_SEPTET = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  // one packed group, or a bare end of stream
  typedef struct packed {
    logic [GROUP_SIZE-1:0][SEPT_W-1:0] low;
    logic [SEPT_W-1:0]                 hdr;
    logic [FILL_W-1:0]                 n;
    logic                              emit;
    logic                              done;
    logic [TOTAL_W-1:0]                total;
  } ssp_job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } ssp_q_stat_t;

endpackage

### rtl/ssp_ifs.sv
// valid/ready channel interfaces for source bytes and packed items
interface ssp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ssp_out_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [6:0]  septet;
  logic [19:0] total_count;
  logic        last_of_run;

  modport source (output valid, output item_kind, output septet, output total_count,
                  output last_of_run, input ready);
  modport sink (input valid, input item_kind, input septet, input total_count,
                input last_of_run, output ready);
endinterface

### rtl/ssp_queue.sv
// short job queue between the byte front end and the item back end
module ssp_queue import ssp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  ssp_job_t    job_in,
  input  logic        pop,
  output ssp_job_t    job_out,
  output ssp_q_stat_t stat
);

  ssp_job_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;
  assign job_out    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= QCNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= QCNT_W'(count - 1'b1);
      end
    end
  end

endmodule

### rtl/ssp_front.sv
// front end: gathers bytes into groups, checks the limit, queues jobs
module ssp_front import ssp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ssp_in_if.sink             byte_in,
  input  logic [LIMIT_W-1:0] output_limit,
  input  logic               q_full,
  output logic               push,
  output ssp_job_t           job
);

  localparam int WIDE = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;
  localparam logic [WIDE-1:0] CMAX = {{(WIDE - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

  logic [GROUP_SIZE-1:0][BYTE_W-1:0] grp;
  logic [FILL_W-1:0]                 fill;
  logic [COUNT_BITS-1:0]             emitted;
  logic                              ovf;

  logic                              acc;
  logic                              complete;
  logic [FILL_W-1:0]                 n;
  logic [GROUP_SIZE-1:0][BYTE_W-1:0] cur;
  logic [WIDE-1:0]                   lim_w;
  logic [WIDE-1:0]                   lim_eff;
  logic [WIDE-1:0]                   sum;
  logic                              fits;
  logic [COUNT_BITS-1:0]             emitted_next;
  logic [WIDE-1:0]                   total_w;

  assign byte_in.ready = !q_full;
  assign acc      = byte_in.valid && byte_in.ready;
  assign complete = (fill == FILL_W'(GROUP_SIZE - 1)) || byte_in.last_byte;
  assign n        = FILL_W'(fill + 1'b1);

  assign lim_w        = WIDE'(output_limit);
  assign lim_eff      = (lim_w < CMAX) ? lim_w : CMAX;
  assign sum          = WIDE'(emitted) + WIDE'(n) + WIDE'(1);
  assign fits         = !ovf && (sum <= lim_eff);
  assign emitted_next = fits ? sum[COUNT_BITS-1:0] : emitted;
  assign total_w      = WIDE'(emitted_next);

  always_comb begin
    for (int j = 0; j < GROUP_SIZE; j++) begin
      cur[j]     = (FILL_W'(j) == fill) ? byte_in.data_byte : grp[j];
      job.low[j] = cur[j][SEPT_W-1:0];
      job.hdr[j] = cur[j][BYTE_W-1] && (FILL_W'(j) <= fill);
    end
    job.n     = n;
    job.emit  = fits;
    job.done  = byte_in.last_byte;
    job.total = total_w[TOTAL_W-1:0];
  end

  assign push = acc && complete && (fits || byte_in.last_byte);

  always_ff @(posedge clk) begin
    if (acc && !complete) begin
      grp[fill] <= byte_in.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      emitted <= '0;
      ovf     <= 1'b0;
    end else if (acc) begin
      if (!complete) begin
        fill <= n;
      end else begin
        fill <= '0;
        if (byte_in.last_byte) begin
          emitted <= '0;
          ovf     <= 1'b0;
        end else begin
          emitted <= emitted_next;
          if (!fits) begin
            ovf <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### rtl/ssp_back.sv
// back end: walks a queued job and sends header, septets and done item
module ssp_back import ssp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     q_empty,
  input  ssp_job_t head,
  output logic     pop,
  ssp_out_if.source item_out
);

  localparam logic [1:0] S_HDR  = 2'd0;
  localparam logic [1:0] S_DATA = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        st;
  logic [1:0]        st_next;
  logic [FILL_W-1:0] idx;
  logic [FILL_W-1:0] idx_next;

  logic               load;
  logic               pop_item;
  logic               o_kind;
  logic [SEPT_W-1:0]  o_sept;
  logic [TOTAL_W-1:0] o_total;
  logic               o_last;

  assign load = !q_empty && (!item_out.valid || item_out.ready);
  assign pop  = load && pop_item;

  always_comb begin
    st_next  = st;
    idx_next = idx;
    pop_item = 1'b0;
    o_kind   = KIND_DONE;
    o_sept   = '0;
    o_total  = head.total;
    o_last   = 1'b1;
    case (st)
      S_HDR: begin
        if (head.emit) begin
          o_kind   = KIND_SEPTET;
          o_sept   = head.hdr;
          o_total  = '0;
          o_last   = 1'b0;
          st_next  = S_DATA;
          idx_next = '0;
        end else begin
          pop_item = 1'b1;
        end
      end
      S_DATA: begin
        o_kind  = KIND_SEPTET;
        o_sept  = head.low[idx];
        o_total = '0;
        o_last  = 1'b0;
        if (idx == FILL_W'(head.n - 1'b1)) begin
          if (head.done) begin
            st_next = S_DONE;
          end else begin
            o_last   = 1'b1;
            pop_item = 1'b1;
            st_next  = S_HDR;
          end
        end else begin
          idx_next = FILL_W'(idx + 1'b1);
        end
      end
      S_DONE: begin
        pop_item = 1'b1;
        st_next  = S_HDR;
      end
      default: begin
        st_next = S_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= S_HDR;
      idx            <= '0;
      item_out.valid <= 1'b0;
    end else begin
      if (load) begin
        st             <= st_next;
        idx            <= idx_next;
        item_out.valid <= 1'b1;
      end else if (item_out.ready) begin
        item_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_out.item_kind   <= o_kind;
      item_out.septet      <= o_sept;
      item_out.total_count <= o_total;
      item_out.last_of_run <= o_last;
    end
  end

endmodule

### rtl/sysex_seven_bit_packer.sv
// top level of the sysex seven-bit packer
//
// byte_in takes one source byte per transfer, with last_byte on the final
// byte of a stream. item_out sends one item per transfer: septet items
// (a header whose bit j is the top bit of byte j, then the low seven bits of
// each byte) and, after a stream's last byte, a done item with the count.
// cfg_wr_en/cfg_wr_data write the output limit; the user must write it only
// while the block is idle, which the block does not enforce. the first item
// caused by a byte passes the job queue and the output register; bytes that
// close no group cause no item. throughput: the front end takes one byte per
// cycle while its two-entry job queue has room; the back end sends one item
// per cycle, so a full group of seven bytes gives eight items, plus one for
// a done item. a stalled receiver holds the output register, the back end
// waits, the queue fills, and byte_in.ready then drops until a job leaves
// the queue. reset empties the queue and output, clears the group and stream
// count, and sets the output limit to its largest value.
`include "sysex_seven_bit_packer_macros.svh"

module sysex_seven_bit_packer import ssp_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  ssp_in_if.sink             byte_in,
  ssp_out_if.source          item_out,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  logic [LIMIT_W-1:0] output_limit;
  logic               q_push;
  logic               q_pop;
  ssp_job_t           job_in;
  ssp_job_t           job_head;
  ssp_q_stat_t        q_stat;
  logic               item_pad_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      output_limit <= cfg_wr_data;
    end
  end

  ssp_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .byte_in      (byte_in),
    .output_limit (output_limit),
    .q_full       (q_stat.full),
    .push         (q_push),
    .job          (job_in)
  );

  ssp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .job_in  (job_in),
    .pop     (q_pop),
    .job_out (job_head),
    .stat    (q_stat)
  );

  ssp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_stat.empty),
    .head     (job_head),
    .pop      (q_pop),
    .item_out (item_out)
  );

  assign item_pad_ok = (item_out.item_kind == KIND_DONE) ? (item_out.septet == '0)
                                                          : (item_out.total_count == '0);

  `SSP_ASSERT_NOW(a_no_push_full, q_push && !q_pop, !q_stat.full, "job pushed into full queue")
  `SSP_ASSERT_NOW(a_count_bound, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overrun")
  `SSP_ASSERT_NOW(a_item_fields, item_out.valid, item_pad_ok, "unused item field not zero")
  `SSP_ASSERT_NEXT(a_drain_empty, q_pop && !q_push && (q_stat.count == QCNT_W'(1)), q_stat.empty, "queue not empty after last pop")

endmodule
